// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SMO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SMO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/smo_pkg.sv =====
// Types and codes for the stack machine block
`default_nettype none

package smo_pkg;

	localparam logic [2:0] CMD_PUSH = 3'd0;
	localparam logic [2:0] CMD_PALL = 3'd1;
	localparam logic [2:0] CMD_POP  = 3'd2;
	localparam logic [2:0] CMD_PINT = 3'd3;
	localparam logic [2:0] CMD_SWAP = 3'd4;

	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_POP_EMPTY  = 3'd1;
	localparam logic [2:0] STAT_PINT_EMPTY = 3'd2;
	localparam logic [2:0] STAT_SWAP_SHORT = 3'd3;
	localparam logic [2:0] STAT_OVERFLOW   = 3'd4;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] word;
		logic [2:0]         status;
		logic               last;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PINT,
		S_PALL,
		S_SWAP_A,
		S_SWAP_B,
		S_SWAP_C,
		S_ERR
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/smo_stream_if.sv =====
// Valid/ready stream channel carrying one payload type
`default_nettype none

interface smo_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stack_machine_ops.sv =====
// Top level of the bounded stack machine
//
//   channel  role    handshake      payload
//   req      sink    valid/ready    cmd[2:0], push_value[31:0] signed
//   res      source  valid/ready    word[31:0] signed, status[2:0], last
//
// Push and pop are done when accepted; pint and errors each issue one result and wait out any output stall.
// Swap does two reads and two writes on the single memory port pair, through S_SWAP_A, S_SWAP_B and S_SWAP_C.
// Pall issues the entries from the top down, paced by the result channel.
// Reset clears the fill count and sequencer; stack entries are not cleared.
// Requests are taken only while the sequencer is idle.
`default_nettype none

module stack_machine_ops #(
	parameter int DEPTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	smo_stream_if.sink   req,
	smo_stream_if.source res
);
	import smo_pkg::*;

	localparam int AW = $clog2(DEPTH);

	smo_stream_if #(.payload_t(res_t)) emit_ch ();

	logic               wr_en, rd_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic signed [31:0] wr_data, rd_data;

	smo_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.emit    (emit_ch),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	smo_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	smo_res_reg u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (emit_ch),
		.dst    (res)
	);
endmodule

`default_nettype wire

// ===== rtl/core/smo_mem.sv =====
// Stack entry memory: one write port, one registered read port
`default_nettype none

module smo_mem #(
	parameter int DEPTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic signed [31:0]           wr_data,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic signed [31:0]                rd_data
);
	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

`default_nettype wire

// ===== rtl/core/smo_res_reg.sv =====
// Result output register between the sequencer and the result channel
`default_nettype none

module smo_res_reg (
	input  wire logic    clk,
	input  wire logic    arst_n,
	smo_stream_if.sink   src,
	smo_stream_if.source dst
);
	import smo_pkg::*;

	logic valid_q;
	res_t data_q;

	// take a new result when empty or when the held one leaves this cycle
	assign src.ready = !valid_q || dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (src.ready) begin
			valid_q <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			data_q <= src.payload;
		end
	end

	assign dst.valid   = valid_q;
	assign dst.payload = data_q;
endmodule

`default_nettype wire

// ===== rtl/core/smo_ctrl.sv =====
// Command sequencer: fill count, memory read-modify-write, result issue
`default_nettype none

module smo_ctrl #(
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	smo_stream_if.sink                    req,
	smo_stream_if.source                  emit,
	output logic                          wr_en,
	output logic [$clog2(DEPTH)-1:0]      wr_addr,
	output logic signed [31:0]            wr_data,
	output logic                          rd_en,
	output logic [$clog2(DEPTH)-1:0]      rd_addr,
	input  wire logic signed [31:0]       rd_data
);
	import smo_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t             state_q, state_nxt;
	logic [CW-1:0]      fill_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] tmp_q;
	logic [2:0]         err_q;

	logic          full, empty, short;
	logic [AW-1:0] top_addr, second_addr;
	logic          accept;
	logic          fail;
	logic [2:0]    fail_code;

	assign full        = fill_q == CW'(DEPTH);
	assign empty       = fill_q == '0;
	assign short       = fill_q < CW'(2);
	assign top_addr    = AW'(fill_q - CW'(1));
	assign second_addr = AW'(fill_q - CW'(2));
	assign accept      = (state_q == S_IDLE) && req.valid;

	// command check against the current fill
	always_comb begin
		fail      = 1'b0;
		fail_code = STAT_OK;
		unique case (req.payload.cmd)
			CMD_PUSH: begin
				fail      = full;
				fail_code = STAT_OVERFLOW;
			end
			CMD_POP: begin
				fail      = empty;
				fail_code = STAT_POP_EMPTY;
			end
			CMD_PINT: begin
				fail      = empty;
				fail_code = STAT_PINT_EMPTY;
			end
			CMD_SWAP: begin
				fail      = short;
				fail_code = STAT_SWAP_SHORT;
			end
			default: begin
				fail      = 1'b0;
				fail_code = STAT_OK;
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (fail) begin
						state_nxt = S_ERR;
					end else begin
						unique case (req.payload.cmd)
							CMD_PALL: state_nxt = empty ? S_IDLE : S_PALL;
							CMD_PINT: state_nxt = S_PINT;
							CMD_SWAP: state_nxt = S_SWAP_A;
							default:  state_nxt = S_IDLE;
						endcase
					end
				end
			end
			S_PINT: if (emit.ready) state_nxt = S_IDLE;
			S_PALL: if (emit.ready && idx_q == '0) state_nxt = S_IDLE;
			S_SWAP_A: state_nxt = S_SWAP_B;
			S_SWAP_B: state_nxt = S_SWAP_C;
			S_SWAP_C: state_nxt = S_IDLE;
			S_ERR: if (emit.ready) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready    = 1'b0;
		emit.valid   = 1'b0;
		emit.payload = '{word: '0, status: STAT_OK, last: 1'b1};
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = req.payload.push_value;
		rd_en        = 1'b0;
		rd_addr      = top_addr;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && !fail) begin
					unique case (req.payload.cmd)
						CMD_PUSH: begin
							wr_en   = 1'b1;
							wr_addr = fill_q[AW-1:0];
						end
						CMD_PALL: rd_en = !empty;
						CMD_PINT: rd_en = 1'b1;
						CMD_SWAP: rd_en = 1'b1;
						default: rd_en = 1'b0;
					endcase
				end
			end
			S_PINT: begin
				emit.valid   = 1'b1;
				emit.payload = '{word: rd_data, status: STAT_OK, last: 1'b1};
			end
			S_PALL: begin
				emit.valid   = 1'b1;
				emit.payload = '{word: rd_data, status: STAT_OK, last: idx_q == '0};
				// fetch the next entry down as this one leaves
				rd_en   = emit.ready && idx_q != '0;
				rd_addr = idx_q - 1'b1;
			end
			S_SWAP_A: begin
				rd_en   = 1'b1;
				rd_addr = second_addr;
			end
			S_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = top_addr;
				wr_data = rd_data;
			end
			S_SWAP_C: begin
				wr_en   = 1'b1;
				wr_addr = second_addr;
				wr_data = tmp_q;
			end
			S_ERR: begin
				emit.valid   = 1'b1;
				emit.payload = '{word: '0, status: err_q, last: 1'b1};
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && !fail) begin
				if (req.payload.cmd == CMD_PUSH) begin
					fill_q <= fill_q + 1'b1;
				end else if (req.payload.cmd == CMD_POP) begin
					fill_q <= fill_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= fail_code;
			idx_q <= top_addr;
		end else if (state_q == S_PALL && emit.ready) begin
			idx_q <= idx_q - 1'b1;
		end
		// hold the old top while the second entry is read
		if (state_q == S_SWAP_A) begin
			tmp_q <= rd_data;
		end
	end
endmodule

`default_nettype wire

// ===== rtl/core/smo_checker.sv =====
// Port-level checks on the stack machine result channel
`default_nettype none
`include "assert_macros.svh"

module smo_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire smo_pkg::res_t res_payload
);
	import smo_pkg::*;

	logic res_err;

	assign res_err = res_valid && res_payload.status != STAT_OK;

	`SMO_ASSERT_NOW(err_is_last, clk, arst_n, res_err, res_payload.last)
	`SMO_ASSERT_NOW(err_word_zero, clk, arst_n, res_err, res_payload.word == '0)
	`SMO_ASSERT_NEXT(res_held, clk, arst_n, res_valid && !res_ready, res_valid)
	`SMO_ASSERT_NEXT(res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_payload))
endmodule

bind stack_machine_ops smo_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stack_machine_ops: directed command table, then random command stream
module tb_top;
	import smo_pkg::*;

	localparam int STACK_DEPTH = 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 285;
	localparam int QUIET_ITEMS = 40;
	localparam int DRAIN_CYCLES = 40;

	typedef enum {ROW_PREDICTED, ROW_SILENT, ROW_SINGLE} row_kind_t;

	typedef struct {
		req_t      request;
		row_kind_t kind;
		res_t      result;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	smo_stream_if #(.payload_t(req_t)) req_ch ();
	smo_stream_if #(.payload_t(res_t)) res_ch ();

	stack_machine_ops #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the stack contents and the results still owed
	logic signed [31:0] shadow_words [STACK_DEPTH];
	int                 shadow_fill;
	res_t               step_results[$];
	res_t               owed_results[$];
	row_t               cmd_table[$];

	row_kind_t row_kind;
	res_t      row_result;
	bit        quiet;
	int        req_gap_pct;
	int        res_stall_pct;
	int        res_stall_left;
	int        errors;
	int unsigned cycle_count;

	function automatic res_t fault_result(input logic [2:0] code);
		res_t r;
		r.word = '0;
		r.status = code;
		r.last = 1'b1;
		return r;
	endfunction

	// apply one request to the shadow stack, collect the results it causes
	function automatic void stack_step(input req_t r);
		res_t               o;
		logic signed [31:0] held;
		step_results.delete();
		case (r.cmd)
			CMD_PUSH: begin
				if (shadow_fill >= STACK_DEPTH) begin
					step_results.push_back(fault_result(STAT_OVERFLOW));
				end else begin
					shadow_words[shadow_fill] = r.push_value;
					shadow_fill++;
				end
			end
			CMD_PALL: begin
				for (int i = shadow_fill - 1; i >= 0; i--) begin
					o.word = shadow_words[i];
					o.status = STAT_OK;
					o.last = (i == 0);
					step_results.push_back(o);
				end
			end
			CMD_POP: begin
				if (shadow_fill == 0)
					step_results.push_back(fault_result(STAT_POP_EMPTY));
				else
					shadow_fill--;
			end
			CMD_PINT: begin
				if (shadow_fill == 0) begin
					step_results.push_back(fault_result(STAT_PINT_EMPTY));
				end else begin
					o.word = shadow_words[shadow_fill - 1];
					o.status = STAT_OK;
					o.last = 1'b1;
					step_results.push_back(o);
				end
			end
			CMD_SWAP: begin
				if (shadow_fill < 2) begin
					step_results.push_back(fault_result(STAT_SWAP_SHORT));
				end else begin
					held = shadow_words[shadow_fill - 1];
					shadow_words[shadow_fill - 1] = shadow_words[shadow_fill - 2];
					shadow_words[shadow_fill - 2] = held;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// check results first, then queue what the newly taken request owes
	always @(posedge clk) begin
		res_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing expected: word %0d status %0d last %0b",
					$time, res_ch.payload.word, res_ch.payload.status, res_ch.payload.last);
				errors++;
			end else begin
				want = owed_results.pop_front();
				if (res_ch.payload.word !== want.word) begin
					$display("%0t: word mismatch: expected %0d, actual %0d",
						$time, want.word, res_ch.payload.word);
					errors++;
				end
				if (res_ch.payload.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, res_ch.payload.status);
					errors++;
				end
				if (res_ch.payload.last !== want.last) begin
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.last, res_ch.payload.last);
					errors++;
				end
			end
		end
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			stack_step(req_ch.payload);
			case (row_kind)
				ROW_PREDICTED: foreach (step_results[k]) owed_results.push_back(step_results[k]);
				ROW_SINGLE: owed_results.push_back(row_result);
				default: begin
				end
			endcase
		end
	end

	// result side backpressure in bursts
	always @(posedge clk) begin
		if (res_stall_left > 0) begin
			res_stall_left--;
			res_ch.ready <= (res_stall_left == 0);
		end else if (!quiet && $urandom_range(0, 99) < res_stall_pct) begin
			res_stall_left = $urandom_range(1, 17);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	function automatic void add_row(input logic [2:0] cmd, input logic signed [31:0] value,
			input row_kind_t kind, input logic signed [31:0] word, input logic [2:0] code);
		row_t r;
		r.request.cmd = cmd;
		r.request.push_value = value;
		r.kind = kind;
		r.result.word = word;
		r.result.status = code;
		r.result.last = 1'b1;
		cmd_table.push_back(r);
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			4, 5: return $signed(32'($urandom_range(0, 255))) - 32'sd128;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic logic [2:0] pick_cmd();
		int p;
		p = $urandom_range(0, 99);
		if (p < 36) return CMD_PUSH;
		if (p < 46) return CMD_PALL;
		if (p < 64) return CMD_POP;
		if (p < 79) return CMD_PINT;
		if (p < 95) return CMD_SWAP;
		return 3'($urandom_range(5, 7));
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	// hold the request until taken, then maybe go idle for a burst
	task automatic send_request(input req_t r, input row_kind_t kind, input res_t typed);
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		row_kind <= kind;
		row_result <= typed;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		if (!quiet && $urandom_range(0, 99) < req_gap_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= req_t'({$urandom(), $urandom()});
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [2:0] cmd, input logic signed [31:0] value,
			inout int taken);
		req_t r;
		r.cmd = cmd;
		r.push_value = value;
		if (taken >= RANDOM_ITEMS - QUIET_ITEMS)
			quiet = 1'b1;
		send_request(r, ROW_PREDICTED, '0);
		if (cmd <= CMD_SWAP)
			taken++;
	endtask

	initial begin
		int taken;
		int run;
		bit fill_pass;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		res_ch.ready = 1'b0;
		row_kind = ROW_PREDICTED;
		row_result = '0;
		quiet = 1'b0;
		req_gap_pct = 10;
		res_stall_pct = 10;
		res_stall_left = 0;
		errors = 0;
		shadow_fill = 0;
		taken = 0;

		add_row(CMD_POP, 32'sd0, ROW_SINGLE, 32'sd0, STAT_POP_EMPTY);
		add_row(CMD_PINT, 32'sd0, ROW_SINGLE, 32'sd0, STAT_PINT_EMPTY);
		add_row(CMD_SWAP, 32'sd0, ROW_SINGLE, 32'sd0, STAT_SWAP_SHORT);
		add_row(CMD_PALL, 32'sd0, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_PUSH, 32'sh8000_0000, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_SWAP, 32'sd0, ROW_SINGLE, 32'sd0, STAT_SWAP_SHORT);
		add_row(CMD_PINT, 32'sd0, ROW_SINGLE, 32'sh8000_0000, STAT_OK);
		add_row(CMD_PUSH, 32'sh7fff_ffff, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_PINT, 32'sd0, ROW_SINGLE, 32'sh7fff_ffff, STAT_OK);
		add_row(CMD_SWAP, 32'sd0, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_PINT, 32'sd0, ROW_SINGLE, 32'sh8000_0000, STAT_OK);
		add_row(CMD_PALL, 32'sd0, ROW_PREDICTED, 32'sd0, STAT_OK);
		add_row(CMD_POP, 32'sd0, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_POP, 32'sd0, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_POP, 32'sd0, ROW_SINGLE, 32'sd0, STAT_POP_EMPTY);
		add_row(3'd5, -32'sd1, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(3'd6, 32'sd0, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(3'd7, 32'sh5555_5555, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_PINT, 32'sd0, ROW_SINGLE, 32'sd0, STAT_PINT_EMPTY);
		add_row(CMD_PUSH, -32'sd1, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_PUSH, 32'sh5555_5555, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_PUSH, 32'shaaaa_aaaa, ROW_SILENT, 32'sd0, STAT_OK);
		add_row(CMD_SWAP, 32'sd0, ROW_PREDICTED, 32'sd0, STAT_OK);
		add_row(CMD_PALL, 32'sd0, ROW_PREDICTED, 32'sd0, STAT_OK);
		add_row(CMD_PINT, 32'sd0, ROW_PREDICTED, 32'sd0, STAT_OK);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (cmd_table[i])
			send_request(cmd_table[i].request, cmd_table[i].kind, cmd_table[i].result);

		// random segments; the first one fills past full, then issues mostly pops to drain it
		fill_pass = 1'b1;
		while (taken < RANDOM_ITEMS) begin
			req_gap_pct = pick_pct();
			res_stall_pct = pick_pct();
			if (fill_pass) begin
				fill_pass = 1'b0;
				run = STACK_DEPTH + $urandom_range(1, 3);
				repeat (run) issue(CMD_PUSH, pick_word(), taken);
				issue(CMD_PALL, pick_word(), taken);
				issue(CMD_SWAP, pick_word(), taken);
				issue(CMD_PINT, pick_word(), taken);
				run = STACK_DEPTH + $urandom_range(1, 3);
				repeat (run) begin
					if ($urandom_range(0, 9) == 0)
						issue(pick_cmd(), pick_word(), taken);
					else
						issue(CMD_POP, pick_word(), taken);
				end
			end else begin
				run = $urandom_range(10, 30);
				repeat (run) issue(pick_cmd(), pick_word(), taken);
				fill_pass = ($urandom_range(0, 9) == 0) && (taken < RANDOM_ITEMS - 80);
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/smo_pkg.sv
rtl/core/smo_stream_if.sv
rtl/core/smo_mem.sv
rtl/core/smo_res_reg.sv
rtl/core/smo_ctrl.sv
rtl/core/stack_machine_ops.sv
rtl/core/smo_checker.sv
sim/tb_top.sv
